@@ rtl/html_text_extractor_macros.svh @@
// Assertion macros shared by the extractor RTL.
`ifndef HTML_TEXT_EXTRACTOR_MACROS_SVH
`define HTML_TEXT_EXTRACTOR_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define HTE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define HTE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/hte_pkg.sv @@
// Shared types, pattern tables and helpers for the HTML text extractor.
package hte_pkg;

   localparam int WINDOW_DEPTH_DEF = 9;
   localparam int NUM_PATTERNS     = 9;
   localparam int MAX_PAT_LEN      = 9;

   typedef enum logic [3:0] {
      PAT_SCRIPT_OPEN,
      PAT_SCRIPT_CLOSE,
      PAT_STYLE_OPEN,
      PAT_STYLE_CLOSE,
      PAT_NBSP,
      PAT_LT,
      PAT_GT,
      PAT_AMP,
      PAT_QUOT
   } pattern_type;

   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_LT      = 8'h3C;
   localparam logic [7:0] CH_GT      = 8'h3E;
   localparam logic [7:0] CH_AMP     = 8'h26;
   localparam logic [7:0] CH_QUOTE   = 8'h22;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_SHIFT = 8'h20;

   localparam logic [3:0] PAT_LEN [NUM_PATTERNS] =
      '{4'd7, 4'd9, 4'd6, 4'd8, 4'd6, 4'd4, 4'd4, 4'd5, 4'd6};

   localparam logic PAT_NOCASE [NUM_PATTERNS] =
      '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};

   // decoded value of each entity; tag patterns carry none
   localparam logic [7:0] PAT_VALUE [NUM_PATTERNS] =
      '{CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_SPACE, CH_LT, CH_GT, CH_AMP, CH_QUOTE};

   localparam logic [7:0] PAT_TEXT [NUM_PATTERNS][MAX_PAT_LEN] = '{
      '{"<", "s", "c", "r", "i", "p", "t", CH_NUL, CH_NUL},
      '{"<", "/", "s", "c", "r", "i", "p", "t", ">"},
      '{"<", "s", "t", "y", "l", "e", CH_NUL, CH_NUL, CH_NUL},
      '{"<", "/", "s", "t", "y", "l", "e", ">", CH_NUL},
      '{"&", "n", "b", "s", "p", ";", CH_NUL, CH_NUL, CH_NUL},
      '{"&", "l", "t", ";", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
      '{"&", "g", "t", ";", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
      '{"&", "a", "m", "p", ";", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
      '{"&", "q", "u", "o", "t", ";", CH_NUL, CH_NUL, CH_NUL}
   };

   typedef enum logic {
      ST_RUN,
      ST_FLUSH
   } mode_type;

   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctrl_type;

   typedef struct packed {
      logic append;
      logic shift;
   } window_ctrl_type;

   typedef struct packed {
      logic [7:0]              head;
      logic [NUM_PATTERNS-1:0] hits;
   } head_view_type;

   typedef struct packed {
      logic go;
      logic clear;
   } judge_ctrl_type;

   typedef struct packed {
      logic       emit;
      logic [7:0] text;
   } judge_result_type;

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
         r = c + CASE_SHIFT;
      end
      return r;
   endfunction

endpackage

@@ rtl/hte_cell.sv @@
// One window cell: a byte register plus its per-position pattern compares.
module hte_cell #(
   parameter int WIN_INDEX = 0
) (
   input  logic                               clock,
   input  hte_pkg::cell_ctrl_type             cell_ctrl,
   input  logic [7:0]                         load_byte,
   input  logic [7:0]                         right_byte,
   output logic [7:0]                         cell_byte,
   output logic [hte_pkg::NUM_PATTERNS-1:0]   cell_hits
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   always_comb begin
      byte_in = byte_ff;
      if (cell_ctrl.load) begin
         byte_in = load_byte;
      end else if (cell_ctrl.shift) begin
         byte_in = right_byte;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign cell_byte = byte_ff;

   generate
      if (WIN_INDEX < hte_pkg::MAX_PAT_LEN) begin : g_cmp
         always_comb begin
            for (int p = 0; p < hte_pkg::NUM_PATTERNS; p++) begin
               if (WIN_INDEX >= int'(hte_pkg::PAT_LEN[p])) begin
                  cell_hits[p] = 1'b1;
               end else if (hte_pkg::PAT_NOCASE[p]) begin
                  cell_hits[p] = hte_pkg::to_lower(byte_ff) ==
                                 hte_pkg::to_lower(hte_pkg::PAT_TEXT[p][WIN_INDEX]);
               end else begin
                  cell_hits[p] = byte_ff == hte_pkg::PAT_TEXT[p][WIN_INDEX];
               end
            end
         end
      end else begin : g_nocmp
         // beyond the longest pattern: never limits a match
         assign cell_hits = '1;
      end
   endgenerate

endmodule

@@ rtl/hte_window.sv @@
// Row of window cells with append and shift control; reports the head view.
module hte_window #(
   parameter int DEPTH  = hte_pkg::WINDOW_DEPTH_DEF,
   parameter int FILL_W = $clog2(DEPTH + 1)
) (
   input  logic                      clock,
   input  hte_pkg::window_ctrl_type  win_ctrl,
   input  logic [FILL_W-1:0]         load_pos,
   input  logic [FILL_W-1:0]         fill,
   input  logic [7:0]                in_byte,
   output hte_pkg::head_view_type    head_view
);

   logic [7:0]                       cell_byte [DEPTH];
   logic [hte_pkg::NUM_PATTERNS-1:0] cell_hits [DEPTH];
   logic [hte_pkg::NUM_PATTERNS-1:0] all_hits;

   generate
      for (genvar i = 0; i < DEPTH; i++) begin : g_cell
         hte_pkg::cell_ctrl_type ctrl;
         logic [7:0]             right;

         assign ctrl.load  = win_ctrl.append && (load_pos == FILL_W'(i));
         assign ctrl.shift = win_ctrl.shift;

         if (i == DEPTH - 1) begin : g_tail
            assign right = hte_pkg::CH_NUL;
         end else begin : g_body
            assign right = cell_byte[i+1];
         end

         hte_cell #(
            .WIN_INDEX (i)
         ) u_cell (
            .clock      (clock),
            .cell_ctrl  (ctrl),
            .load_byte  (in_byte),
            .right_byte (right),
            .cell_byte  (cell_byte[i]),
            .cell_hits  (cell_hits[i])
         );
      end
   endgenerate

   always_comb begin
      all_hits = '1;
      for (int i = 0; i < DEPTH; i++) begin
         all_hits = all_hits & cell_hits[i];
      end
   end

   // a pattern longer than the bytes held does not match
   always_comb begin
      head_view.head = cell_byte[0];
      for (int p = 0; p < hte_pkg::NUM_PATTERNS; p++) begin
         head_view.hits[p] = all_hits[p] && (int'(fill) >= int'(hte_pkg::PAT_LEN[p]));
      end
   end

endmodule

@@ rtl/hte_judge.sv @@
// Head-byte judgement: tag, script, style and skip flags plus text emission.
module hte_judge (
   input  logic                      clock,
   input  logic                      reset,
   input  hte_pkg::judge_ctrl_type   judge_ctrl,
   input  hte_pkg::head_view_type    head_view,
   output hte_pkg::judge_result_type judge_result
);

   logic [3:0] skip_ff, skip_in;
   logic       tag_ff, tag_in;
   logic       script_ff, script_in;
   logic       style_ff, style_in;
   logic       prev_space_ff, prev_space_in;

   logic [7:0] c;
   logic       ent_hit;
   logic [7:0] ent_value;
   logic [3:0] ent_skip;
   logic       is_text;
   logic [7:0] text_val;

   always_comb begin
      ent_hit   = 1'b0;
      ent_value = hte_pkg::CH_NUL;
      ent_skip  = '0;
      // scan backwards so the first entity in table order wins
      for (int p = hte_pkg::NUM_PATTERNS - 1; p >= int'(hte_pkg::PAT_NBSP); p--) begin
         if (head_view.hits[p]) begin
            ent_hit   = 1'b1;
            ent_value = hte_pkg::PAT_VALUE[p];
            ent_skip  = hte_pkg::PAT_LEN[p] - 4'd1;
         end
      end
   end

   always_comb begin
      c             = head_view.head;
      skip_in       = skip_ff;
      tag_in        = tag_ff;
      script_in     = script_ff;
      style_in      = style_ff;
      prev_space_in = prev_space_ff;
      is_text       = 1'b0;
      text_val      = c;
      judge_result  = '0;

      if (skip_ff != 4'd0) begin
         skip_in = skip_ff - 4'd1;
      end else if (c == hte_pkg::CH_LT) begin
         if (head_view.hits[hte_pkg::PAT_SCRIPT_OPEN]) begin
            script_in = 1'b1;
            tag_in    = 1'b1;
         end else if (head_view.hits[hte_pkg::PAT_SCRIPT_CLOSE]) begin
            script_in = 1'b0;
            skip_in   = hte_pkg::PAT_LEN[hte_pkg::PAT_SCRIPT_CLOSE] - 4'd1;
         end else if (head_view.hits[hte_pkg::PAT_STYLE_OPEN]) begin
            style_in = 1'b1;
            tag_in   = 1'b1;
         end else if (head_view.hits[hte_pkg::PAT_STYLE_CLOSE]) begin
            style_in = 1'b0;
            skip_in  = hte_pkg::PAT_LEN[hte_pkg::PAT_STYLE_CLOSE] - 4'd1;
         end else begin
            tag_in = 1'b1;
         end
      end else if (c == hte_pkg::CH_GT) begin
         tag_in = 1'b0;
      end else if (tag_ff || script_ff || style_ff) begin
         is_text = 1'b0;
      end else begin
         is_text = 1'b1;
         if (c == hte_pkg::CH_AMP && ent_hit) begin
            text_val = ent_value;
            skip_in  = ent_skip;
         end
      end

      if (is_text) begin
         if (text_val inside {hte_pkg::CH_SPACE, hte_pkg::CH_TAB,
                              hte_pkg::CH_LF, hte_pkg::CH_CR}) begin
            if (!prev_space_ff) begin
               prev_space_in     = 1'b1;
               judge_result.emit = 1'b1;
               judge_result.text = hte_pkg::CH_SPACE;
            end
         end else begin
            prev_space_in     = 1'b0;
            judge_result.emit = 1'b1;
            judge_result.text = text_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || judge_ctrl.clear) begin
         skip_ff       <= '0;
         tag_ff        <= 1'b0;
         script_ff     <= 1'b0;
         style_ff      <= 1'b0;
         prev_space_ff <= 1'b1;
      end else if (judge_ctrl.go) begin
         skip_ff       <= skip_in;
         tag_ff        <= tag_in;
         script_ff     <= script_in;
         style_ff      <= style_in;
         prev_space_ff <= prev_space_in;
      end
   end

endmodule

@@ rtl/html_text_extractor.sv @@
// Top level of the streaming HTML text extractor.
//
//   channel | direction | ports                                   | accepted when
//   req     | in        | req_in_byte, req_end_of_doc             | req_valid && req_ready
//   rsp     | out       | rsp_text_byte, rsp_has_byte,            | rsp_valid && rsp_ready
//           |           | rsp_doc_done, rsp_last_of_run           |
//
// One request per cycle in steady state, unless a stalled response holds a full window.
// An end_of_doc request flushes each held byte, then an end marker, via the single head
// judge and one output register; no request is taken meanwhile. Synchronous active-high
// reset clears the fill count, mode and flags; the window bytes are not cleared. A stalled
// response holds the head judge and, with a full window, req.
`include "html_text_extractor_macros.svh"

module html_text_extractor #(
   parameter int WINDOW_DEPTH = hte_pkg::WINDOW_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_doc,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_text_byte,
   output logic       rsp_has_byte,
   output logic       rsp_doc_done,
   output logic       rsp_last_of_run
);

   localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);

   hte_pkg::mode_type         state_ff, state_in;
   logic [FILL_W-1:0]         fill_ff, fill_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [7:0]                rsp_text_ff, rsp_text_in;
   logic                      rsp_has_ff, rsp_has_in;
   logic                      rsp_done_ff, rsp_done_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic                      out_free;
   logic                      judge_go;
   logic                      mark_go;
   logic                      in_run;
   logic                      accept;
   logic [FILL_W-1:0]         load_pos;
   hte_pkg::window_ctrl_type  win_ctrl;
   hte_pkg::head_view_type    head_view;
   hte_pkg::judge_ctrl_type   judge_ctrl;
   hte_pkg::judge_result_type judge_result;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // next mode
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hte_pkg::ST_RUN: begin
            if (accept && req_end_of_doc) begin
               state_in = hte_pkg::ST_FLUSH;
            end
         end
         hte_pkg::ST_FLUSH: begin
            if (mark_go) begin
               state_in = hte_pkg::ST_RUN;
            end
         end
         default: state_in = hte_pkg::ST_RUN;
      endcase
   end

   // mode outputs
   always_comb begin
      judge_go  = 1'b0;
      mark_go   = 1'b0;
      req_ready = 1'b0;
      in_run    = 1'b0;
      case (state_ff)
         hte_pkg::ST_RUN: begin
            in_run    = 1'b1;
            judge_go  = (fill_ff == FILL_W'(WINDOW_DEPTH)) && out_free;
            req_ready = (fill_ff != FILL_W'(WINDOW_DEPTH)) || out_free;
         end
         hte_pkg::ST_FLUSH: begin
            judge_go = (fill_ff != '0) && out_free;
            mark_go  = (fill_ff == '0) && out_free;
         end
         default: begin
            in_run = 1'b0;
         end
      endcase
   end

   assign accept   = req_valid && req_ready;
   assign load_pos = fill_ff - FILL_W'(judge_go);
   assign fill_in  = fill_ff - FILL_W'(judge_go) + FILL_W'(accept);

   assign win_ctrl.append = accept;
   assign win_ctrl.shift  = judge_go;

   assign judge_ctrl.go    = judge_go;
   assign judge_ctrl.clear = mark_go;

   hte_window #(
      .DEPTH  (WINDOW_DEPTH),
      .FILL_W (FILL_W)
   ) u_window (
      .clock     (clock),
      .win_ctrl  (win_ctrl),
      .load_pos  (load_pos),
      .fill      (fill_ff),
      .in_byte   (req_in_byte),
      .head_view (head_view)
   );

   hte_judge u_judge (
      .clock        (clock),
      .reset        (reset),
      .judge_ctrl   (judge_ctrl),
      .head_view    (head_view),
      .judge_result (judge_result)
   );

   // output register; flush text results are not the last of their request, the end marker is
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_text_in  = rsp_text_ff;
      rsp_has_in   = rsp_has_ff;
      rsp_done_in  = rsp_done_ff;
      rsp_last_in  = rsp_last_ff;
      if (judge_go && judge_result.emit) begin
         rsp_valid_in = 1'b1;
         rsp_text_in  = judge_result.text;
         rsp_has_in   = 1'b1;
         rsp_done_in  = 1'b0;
         rsp_last_in  = in_run;
      end else if (mark_go) begin
         rsp_valid_in = 1'b1;
         rsp_text_in  = hte_pkg::CH_NUL;
         rsp_has_in   = 1'b0;
         rsp_done_in  = 1'b1;
         rsp_last_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hte_pkg::ST_RUN;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_text_ff <= rsp_text_in;
      rsp_has_ff  <= rsp_has_in;
      rsp_done_ff <= rsp_done_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_text_byte   = rsp_text_ff;
   assign rsp_has_byte    = rsp_has_ff;
   assign rsp_doc_done    = rsp_done_ff;
   assign rsp_last_of_run = rsp_last_ff;

   `HTE_ASSERT_NOW(a_fill_bound, 1'b1, fill_ff <= FILL_W'(WINDOW_DEPTH), "window overfilled")
   `HTE_ASSERT_NOW(a_no_req_in_flush, state_ff == hte_pkg::ST_FLUSH, !req_ready, "request taken in flush")
   `HTE_ASSERT_NEXT(a_end_starts_flush, accept && req_end_of_doc, state_ff == hte_pkg::ST_FLUSH, "end of document did not flush")
   `HTE_ASSERT_NEXT(a_mark_clears, mark_go, state_ff == hte_pkg::ST_RUN && fill_ff == '0 && rsp_valid_ff && rsp_doc_done, "end marker did not restart")

endmodule
